// ===== hw/rtl/mieu_pkg.sv =====
// ----------------------------------------------------------------------------
// mieu_pkg
// Opcode, function and regimm codes plus reset constants for the MIPS64
// integer execute unit.
// ----------------------------------------------------------------------------
package mieu_pkg;

   localparam int unsigned XLEN      = 64;
   localparam int unsigned NUM_REGS  = 32;
   localparam int unsigned REG_IDX_W = 5;

   localparam logic [31:0] START_ADDRESS_RESET = 32'hBFC0_0000;
   localparam logic [4:0]  LINK_REG            = 5'd31;

   typedef logic [5:0] opcode_type;

   // primary opcodes
   localparam opcode_type OP_SPECIAL = 6'h00;
   localparam opcode_type OP_REGIMM  = 6'h01;
   localparam opcode_type OP_J       = 6'h02;
   localparam opcode_type OP_JAL     = 6'h03;
   localparam opcode_type OP_BEQ     = 6'h04;
   localparam opcode_type OP_BNE     = 6'h05;
   localparam opcode_type OP_BLEZ    = 6'h06;
   localparam opcode_type OP_BGTZ    = 6'h07;
   localparam opcode_type OP_ADDIU   = 6'h09;
   localparam opcode_type OP_SLTI    = 6'h0a;
   localparam opcode_type OP_SLTIU   = 6'h0b;
   localparam opcode_type OP_ANDI    = 6'h0c;
   localparam opcode_type OP_ORI     = 6'h0d;
   localparam opcode_type OP_XORI    = 6'h0e;
   localparam opcode_type OP_LUI     = 6'h0f;
   localparam opcode_type OP_DADDIU  = 6'h19;

   // special function codes
   localparam opcode_type FN_SLL    = 6'h00;
   localparam opcode_type FN_SRL    = 6'h02;
   localparam opcode_type FN_SRA    = 6'h03;
   localparam opcode_type FN_SLLV   = 6'h04;
   localparam opcode_type FN_SRLV   = 6'h06;
   localparam opcode_type FN_SRAV   = 6'h07;
   localparam opcode_type FN_JR     = 6'h08;
   localparam opcode_type FN_JALR   = 6'h09;
   localparam opcode_type FN_SYNC   = 6'h0f;
   localparam opcode_type FN_MFHI   = 6'h10;
   localparam opcode_type FN_MTHI   = 6'h11;
   localparam opcode_type FN_MFLO   = 6'h12;
   localparam opcode_type FN_MTLO   = 6'h13;
   localparam opcode_type FN_DSLLV  = 6'h14;
   localparam opcode_type FN_DSRLV  = 6'h16;
   localparam opcode_type FN_DSRAV  = 6'h17;
   localparam opcode_type FN_ADDU   = 6'h21;
   localparam opcode_type FN_SUBU   = 6'h23;
   localparam opcode_type FN_AND    = 6'h24;
   localparam opcode_type FN_OR     = 6'h25;
   localparam opcode_type FN_XOR    = 6'h26;
   localparam opcode_type FN_NOR    = 6'h27;
   localparam opcode_type FN_SLT    = 6'h2a;
   localparam opcode_type FN_SLTU   = 6'h2b;
   localparam opcode_type FN_DADDU  = 6'h2d;
   localparam opcode_type FN_DSUBU  = 6'h2f;
   localparam opcode_type FN_DSLL   = 6'h38;
   localparam opcode_type FN_DSRL   = 6'h3a;
   localparam opcode_type FN_DSRA   = 6'h3b;
   localparam opcode_type FN_DSLL32 = 6'h3c;
   localparam opcode_type FN_DSRL32 = 6'h3e;
   localparam opcode_type FN_DSRA32 = 6'h3f;

   // regimm rt codes
   localparam logic [4:0] RI_BLTZ   = 5'h00;
   localparam logic [4:0] RI_BGEZ   = 5'h01;
   localparam logic [4:0] RI_BLTZAL = 5'h10;
   localparam logic [4:0] RI_BGEZAL = 5'h11;

   function automatic logic [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

endpackage

// ===== hw/rtl/mips64_integer_execute_unit.sv =====
// ----------------------------------------------------------------------------
// mips64_integer_execute_unit
// Decodes and executes one MIPS64 integer instruction per item, with a
// 32 x 64 register file, hi/lo and a delay-slot pc pair.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | req_instr_word
//  rsp     | out       | rsp_valid/rsp_ready | fetch address, reg write, branch, unsup
//  csr     | in        | csr_wr_en           | csr_wr_data (start address)
//
// The accept edge captures the item and its register file operands in the
// operand register; the executed result is captured in the result registers
// when the operand stage fires. One item per cycle sustained while rsp_ready
// holds; the register file read port is bypassed from the write of the item
// executing in the same cycle. Reset clears the register file valid bits at
// once, so no clearing pass. A stalled result holds the operand stage, which
// keeps taking a new item only when it advances.
module mips64_integer_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_fetch_address,
   output logic        rsp_reg_write,
   output logic [4:0]  rsp_reg_index,
   output logic [63:0] rsp_reg_value,
   output logic        rsp_branch_taken,
   output logic        rsp_unsupported,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [63:0] mem [mieu_pkg::NUM_REGS];
   logic [mieu_pkg::NUM_REGS-1:0] rf_valid_ff;

   logic        s1_valid_ff;
   logic [31:0] instr_ff;
   logic [63:0] mem_a_ff, mem_b_ff, fwd_ff;
   logic        va_ff, vb_ff, fa_ff, fb_ff;

   logic [63:0] hi_ff, lo_ff, cur_pc_ff, follow_pc_ff;

   logic        fire, accept;

   // execute results
   logic        wr_en, taken, unsup, hi_we, lo_we;
   logic [4:0]  wr_idx;
   logic [63:0] wr_val, dest;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sa, ri_rs, ri_rt;
   logic [63:0] a, b, imm, zimm, link, target, jtarget, follow_in;

   assign fire      = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !s1_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   assign ri_rs = req_instr_word[25:21];
   assign ri_rt = req_instr_word[20:16];

   // register file: read on accept, write at execute
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_a_ff <= mem[ri_rs];
         mem_b_ff <= mem[ri_rt];
      end
      if (fire && wr_en) begin
         mem[wr_idx] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         instr_ff <= req_instr_word;
         va_ff    <= rf_valid_ff[ri_rs];
         vb_ff    <= rf_valid_ff[ri_rt];
         fa_ff    <= fire && wr_en && (wr_idx == ri_rs);
         fb_ff    <= fire && wr_en && (wr_idx == ri_rt);
         fwd_ff   <= wr_val;
      end
   end

   assign a = fa_ff ? fwd_ff : (va_ff ? mem_a_ff : 64'd0);
   assign b = fb_ff ? fwd_ff : (vb_ff ? mem_b_ff : 64'd0);

   assign op   = instr_ff[31:26];
   assign rs   = instr_ff[25:21];
   assign rt   = instr_ff[20:16];
   assign rd   = instr_ff[15:11];
   assign sa   = instr_ff[10:6];
   assign fn   = instr_ff[5:0];
   assign imm  = {{48{instr_ff[15]}}, instr_ff[15:0]};
   assign zimm = {48'd0, instr_ff[15:0]};
   assign link    = follow_pc_ff + 64'd4;
   assign target  = follow_pc_ff + {imm[61:0], 2'b00};
   assign jtarget = {follow_pc_ff[63:28], instr_ff[25:0], 2'b00};

   always_comb begin
      wr_en  = 1'b0;
      wr_idx = rd;
      wr_val = '0;
      taken  = 1'b0;
      dest   = '0;
      unsup  = 1'b0;
      hi_we  = 1'b0;
      lo_we  = 1'b0;
      priority case (1'b1)
         op == mieu_pkg::OP_SPECIAL: begin
            wr_en = 1'b1;
            unique case (fn)
               mieu_pkg::FN_SLL:    wr_val = mieu_pkg::sext32(b[31:0] << sa);
               mieu_pkg::FN_SRL:    wr_val = mieu_pkg::sext32(b[31:0] >> sa);
               mieu_pkg::FN_SRA:    wr_val = mieu_pkg::sext32(32'($signed(b) >>> sa));
               mieu_pkg::FN_SLLV:   wr_val = mieu_pkg::sext32(b[31:0] << a[4:0]);
               mieu_pkg::FN_SRLV:   wr_val = mieu_pkg::sext32(b[31:0] >> a[4:0]);
               mieu_pkg::FN_SRAV:   wr_val = mieu_pkg::sext32(32'($signed(b) >>> a[4:0]));
               mieu_pkg::FN_JR: begin
                  wr_en = 1'b0;
                  taken = 1'b1;
                  dest  = a;
               end
               mieu_pkg::FN_JALR: begin
                  wr_val = link;
                  taken  = 1'b1;
                  dest   = a;
               end
               mieu_pkg::FN_SYNC:   wr_en = 1'b0;
               mieu_pkg::FN_MFHI:   wr_val = hi_ff;
               mieu_pkg::FN_MTHI: begin
                  wr_en = 1'b0;
                  hi_we = 1'b1;
               end
               mieu_pkg::FN_MFLO:   wr_val = lo_ff;
               mieu_pkg::FN_MTLO: begin
                  wr_en = 1'b0;
                  lo_we = 1'b1;
               end
               mieu_pkg::FN_DSLLV:  wr_val = b << a[5:0];
               mieu_pkg::FN_DSRLV:  wr_val = b >> a[5:0];
               mieu_pkg::FN_DSRAV:  wr_val = 64'($signed(b) >>> a[5:0]);
               mieu_pkg::FN_ADDU:   wr_val = mieu_pkg::sext32(a[31:0] + b[31:0]);
               mieu_pkg::FN_SUBU:   wr_val = mieu_pkg::sext32(a[31:0] - b[31:0]);
               mieu_pkg::FN_AND:    wr_val = a & b;
               mieu_pkg::FN_OR:     wr_val = a | b;
               mieu_pkg::FN_XOR:    wr_val = a ^ b;
               mieu_pkg::FN_NOR:    wr_val = ~(a | b);
               mieu_pkg::FN_SLT:    wr_val = {63'd0, $signed(a) < $signed(b)};
               mieu_pkg::FN_SLTU:   wr_val = {63'd0, a < b};
               mieu_pkg::FN_DADDU:  wr_val = a + b;
               mieu_pkg::FN_DSUBU:  wr_val = a - b;
               mieu_pkg::FN_DSLL:   wr_val = b << sa;
               mieu_pkg::FN_DSRL:   wr_val = b >> sa;
               mieu_pkg::FN_DSRA:   wr_val = 64'($signed(b) >>> sa);
               mieu_pkg::FN_DSLL32: wr_val = b << {1'b1, sa};
               mieu_pkg::FN_DSRL32: wr_val = b >> {1'b1, sa};
               mieu_pkg::FN_DSRA32: wr_val = 64'($signed(b) >>> {1'b1, sa});
               default: begin
                  wr_en = 1'b0;
                  unsup = 1'b1;
               end
            endcase
         end
         op == mieu_pkg::OP_REGIMM: begin
            dest   = target;
            wr_idx = mieu_pkg::LINK_REG;
            wr_val = mieu_pkg::sext32(link[31:0]);
            unique case (rt)
               mieu_pkg::RI_BLTZ: taken = a[63];
               mieu_pkg::RI_BGEZ: taken = !a[63];
               mieu_pkg::RI_BLTZAL: begin
                  // link lands before rs is tested
                  wr_en = 1'b1;
                  taken = (rs == mieu_pkg::LINK_REG) ? link[31] : a[63];
               end
               mieu_pkg::RI_BGEZAL: begin
                  wr_en = 1'b1;
                  taken = !a[63];
               end
               default: unsup = 1'b1;
            endcase
         end
         default: begin
            wr_idx = rt;
            dest   = target;
            wr_en  = 1'b1;
            unique case (op)
               mieu_pkg::OP_J: begin
                  wr_en = 1'b0;
                  taken = 1'b1;
                  dest  = jtarget;
               end
               mieu_pkg::OP_JAL: begin
                  wr_idx = mieu_pkg::LINK_REG;
                  wr_val = link;
                  taken  = 1'b1;
                  dest   = jtarget;
               end
               mieu_pkg::OP_BEQ: begin
                  wr_en = 1'b0;
                  taken = (a == b);
               end
               mieu_pkg::OP_BNE: begin
                  wr_en = 1'b0;
                  taken = (a != b);
               end
               mieu_pkg::OP_BLEZ: begin
                  wr_en = 1'b0;
                  taken = a[63] || (a == 64'd0);
               end
               mieu_pkg::OP_BGTZ: begin
                  wr_en = 1'b0;
                  taken = !a[63] && (a != 64'd0);
               end
               mieu_pkg::OP_ADDIU:  wr_val = mieu_pkg::sext32(a[31:0] + imm[31:0]);
               mieu_pkg::OP_SLTI:   wr_val = {63'd0, $signed(a) < $signed(imm)};
               mieu_pkg::OP_SLTIU:  wr_val = {63'd0, a < imm};
               mieu_pkg::OP_ANDI:   wr_val = a & zimm;
               mieu_pkg::OP_ORI:    wr_val = a | zimm;
               mieu_pkg::OP_XORI:   wr_val = a ^ zimm;
               mieu_pkg::OP_LUI:    wr_val = mieu_pkg::sext32({instr_ff[15:0], 16'd0});
               mieu_pkg::OP_DADDIU: wr_val = a + imm;
               default: begin
                  wr_en = 1'b0;
                  unsup = 1'b1;
               end
            endcase
         end
      endcase
      // drop writes to r0
      if (wr_idx == '0) begin
         wr_en = 1'b0;
      end
   end

   assign follow_in = taken ? dest : link;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid    <= 1'b0;
         rf_valid_ff  <= '0;
         hi_ff        <= '0;
         lo_ff        <= '0;
         cur_pc_ff    <= mieu_pkg::sext32(mieu_pkg::START_ADDRESS_RESET);
         follow_pc_ff <= mieu_pkg::sext32(mieu_pkg::START_ADDRESS_RESET) + 64'd4;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         if (fire) begin
            if (wr_en) begin
               rf_valid_ff[wr_idx] <= 1'b1;
            end
            if (hi_we) begin
               hi_ff <= a;
            end
            if (lo_we) begin
               lo_ff <= a;
            end
            cur_pc_ff    <= follow_pc_ff;
            follow_pc_ff <= follow_in;
         end
         if (csr_wr_en) begin
            cur_pc_ff    <= mieu_pkg::sext32(csr_wr_data);
            follow_pc_ff <= mieu_pkg::sext32(csr_wr_data) + 64'd4;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_fetch_address <= follow_pc_ff;
         rsp_reg_write     <= wr_en;
         rsp_reg_index     <= wr_en ? wr_idx : 5'd0;
         rsp_reg_value     <= wr_en ? wr_val : 64'd0;
         rsp_branch_taken  <= taken;
         rsp_unsupported   <= unsup;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_write |-> rsp_reg_index != 5'd0)
      else $error("r0 reported as written");

   a_unsup_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unsupported |-> !rsp_reg_write && !rsp_branch_taken)
      else $error("unsupported item had side effects");

   a_r0_never_valid: assert property (@(posedge clock) disable iff (reset)
      !rf_valid_ff[0])
      else $error("r0 marked as written");

   a_pc_step: assert property (@(posedge clock) disable iff (reset)
      fire && !csr_wr_en |=> cur_pc_ff == $past(follow_pc_ff))
      else $error("pc pair did not advance");
`endif

endmodule

// ===== tb/tb_mips64_integer_execute_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mips64_integer_execute_unit
// Streams MIPS64 integer instruction words into the execute unit under random
// burst and stall patterns. A behavioral model of the register file, hi/lo and
// delay-slot pc pair predicts each result, and the monitor checks every field.
// ----------------------------------------------------------------------------
module tb_mips64_integer_execute_unit;

   typedef struct packed {
      logic [63:0] fetch_address;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [63:0] reg_value;
      logic        branch_taken;
      logic        unsupported;
   } exec_result_type;

   // codes outside the handled subset
   localparam logic [5:0] OP_LW       = 6'h23;
   localparam logic [5:0] FN_UNLISTED = 6'h3d;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_instr_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_fetch_address;
   logic        rsp_reg_write;
   logic [4:0]  rsp_reg_index;
   logic [63:0] rsp_reg_value;
   logic        rsp_branch_taken;
   logic        rsp_unsupported;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   mips64_integer_execute_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_instr_word(req_instr_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_fetch_address(rsp_fetch_address), .rsp_reg_write(rsp_reg_write),
      .rsp_reg_index(rsp_reg_index), .rsp_reg_value(rsp_reg_value),
      .rsp_branch_taken(rsp_branch_taken), .rsp_unsupported(rsp_unsupported),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // architectural state of the model
   logic [63:0]     gpr [32];
   logic [63:0]     hi_q, lo_q, pc_q, npc_q;
   logic [31:0]     instr_queue [$];
   exec_result_type expected_results [$];
   int              mismatches = 0;
   bit              pausing = 1'b0;
   bit              stim_done = 1'b0;

   function automatic logic [63:0] sx32(input logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

   function automatic logic [63:0] slt_s(input logic [63:0] a, input logic [63:0] b);
      return ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
   endfunction

   task automatic reload_pc(input logic [31:0] start);
      pc_q  = sx32({32'd0, start});
      npc_q = pc_q + 64'd4;
   endtask

   // advance the model by one instruction and queue its result
   task automatic execute_instr(input logic [31:0] w);
      logic [5:0]      op, fn;
      logic [4:0]      rs, rt, rd, sa;
      logic [63:0]     a, b, imm, zimm, tgt, jtgt, nf;
      exec_result_type r;
      op = w[31:26]; fn = w[5:0];
      rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sa = w[10:6];
      a = gpr[rs]; b = gpr[rt];
      imm = {{48{w[15]}}, w[15:0]};
      zimm = {48'd0, w[15:0]};
      tgt = npc_q + (imm << 2);
      jtgt = (npc_q & ~64'h0fff_ffff) | {36'd0, w[25:0], 2'b00};
      nf = npc_q + 64'd4;
      r = '0;
      if (op == mieu_pkg::OP_SPECIAL) begin
         r.reg_index = rd;
         r.reg_write = 1'b1;
         case (fn)
            mieu_pkg::FN_SLL:    r.reg_value = sx32(b << sa);
            mieu_pkg::FN_SRL:    r.reg_value = sx32({32'd0, b[31:0]} >> sa);
            mieu_pkg::FN_SRA:    r.reg_value = sx32($signed(b) >>> sa);
            mieu_pkg::FN_SLLV:   r.reg_value = sx32(b << a[4:0]);
            mieu_pkg::FN_SRLV:   r.reg_value = sx32({32'd0, b[31:0]} >> a[4:0]);
            mieu_pkg::FN_SRAV:   r.reg_value = sx32($signed(b) >>> a[4:0]);
            mieu_pkg::FN_JR: begin
               r.reg_write = 1'b0; r.branch_taken = 1'b1; nf = a;
            end
            mieu_pkg::FN_JALR: begin
               r.reg_value = npc_q + 64'd4; r.branch_taken = 1'b1; nf = a;
            end
            mieu_pkg::FN_SYNC:   r.reg_write = 1'b0;
            mieu_pkg::FN_MFHI:   r.reg_value = hi_q;
            mieu_pkg::FN_MTHI: begin
               r.reg_write = 1'b0; hi_q = a;
            end
            mieu_pkg::FN_MFLO:   r.reg_value = lo_q;
            mieu_pkg::FN_MTLO: begin
               r.reg_write = 1'b0; lo_q = a;
            end
            mieu_pkg::FN_DSLLV:  r.reg_value = b << a[5:0];
            mieu_pkg::FN_DSRLV:  r.reg_value = b >> a[5:0];
            mieu_pkg::FN_DSRAV:  r.reg_value = $signed(b) >>> a[5:0];
            mieu_pkg::FN_ADDU:   r.reg_value = sx32(a + b);
            mieu_pkg::FN_SUBU:   r.reg_value = sx32(a - b);
            mieu_pkg::FN_AND:    r.reg_value = a & b;
            mieu_pkg::FN_OR:     r.reg_value = a | b;
            mieu_pkg::FN_XOR:    r.reg_value = a ^ b;
            mieu_pkg::FN_NOR:    r.reg_value = ~(a | b);
            mieu_pkg::FN_SLT:    r.reg_value = slt_s(a, b);
            mieu_pkg::FN_SLTU:   r.reg_value = (a < b) ? 64'd1 : 64'd0;
            mieu_pkg::FN_DADDU:  r.reg_value = a + b;
            mieu_pkg::FN_DSUBU:  r.reg_value = a - b;
            mieu_pkg::FN_DSLL:   r.reg_value = b << sa;
            mieu_pkg::FN_DSRL:   r.reg_value = b >> sa;
            mieu_pkg::FN_DSRA:   r.reg_value = $signed(b) >>> sa;
            mieu_pkg::FN_DSLL32: r.reg_value = b << (sa + 32);
            mieu_pkg::FN_DSRL32: r.reg_value = b >> (sa + 32);
            mieu_pkg::FN_DSRA32: r.reg_value = $signed(b) >>> (sa + 32);
            default: begin
               r.reg_write = 1'b0; r.unsupported = 1'b1;
            end
         endcase
      end else if (op == mieu_pkg::OP_REGIMM) begin
         r.reg_index = mieu_pkg::LINK_REG;
         r.reg_value = sx32(npc_q + 64'd4);
         case (rt)
            mieu_pkg::RI_BLTZ: begin
               r.reg_index = '0; r.reg_value = '0; r.branch_taken = a[63];
            end
            mieu_pkg::RI_BGEZ: begin
               r.reg_index = '0; r.reg_value = '0; r.branch_taken = !a[63];
            end
            // link lands first, so rs = 31 tests the link value
            mieu_pkg::RI_BLTZAL: begin
               r.reg_write = 1'b1;
               r.branch_taken = (rs == mieu_pkg::LINK_REG) ? r.reg_value[63] : a[63];
            end
            mieu_pkg::RI_BGEZAL: begin
               r.reg_write = 1'b1; r.branch_taken = !a[63];
            end
            default: begin
               r.reg_index = '0; r.reg_value = '0; r.unsupported = 1'b1;
            end
         endcase
         if (r.branch_taken) nf = tgt;
      end else begin
         r.reg_index = rt;
         r.reg_write = 1'b1;
         case (op)
            mieu_pkg::OP_J: begin
               r.reg_write = 1'b0; r.branch_taken = 1'b1; nf = jtgt;
            end
            mieu_pkg::OP_JAL: begin
               r.reg_index = mieu_pkg::LINK_REG; r.reg_value = npc_q + 64'd4;
               r.branch_taken = 1'b1; nf = jtgt;
            end
            mieu_pkg::OP_BEQ:    r.branch_taken = (a == b);
            mieu_pkg::OP_BNE:    r.branch_taken = (a != b);
            mieu_pkg::OP_BLEZ:   r.branch_taken = a[63] || a == 64'd0;
            mieu_pkg::OP_BGTZ:   r.branch_taken = !a[63] && a != 64'd0;
            mieu_pkg::OP_ADDIU:  r.reg_value = sx32(a + imm);
            mieu_pkg::OP_SLTI:   r.reg_value = slt_s(a, imm);
            mieu_pkg::OP_SLTIU:  r.reg_value = (a < imm) ? 64'd1 : 64'd0;
            mieu_pkg::OP_ANDI:   r.reg_value = a & zimm;
            mieu_pkg::OP_ORI:    r.reg_value = a | zimm;
            mieu_pkg::OP_XORI:   r.reg_value = a ^ zimm;
            mieu_pkg::OP_LUI:    r.reg_value = sx32({32'd0, w[15:0], 16'd0});
            mieu_pkg::OP_DADDIU: r.reg_value = a + imm;
            default: begin
               r.reg_write = 1'b0; r.unsupported = 1'b1;
            end
         endcase
         if (op inside {mieu_pkg::OP_BEQ, mieu_pkg::OP_BNE, mieu_pkg::OP_BLEZ,
                        mieu_pkg::OP_BGTZ}) begin
            r.reg_write = 1'b0;
            if (r.branch_taken) nf = tgt;
         end
      end
      if (!r.reg_write) begin
         r.reg_index = '0; r.reg_value = '0;
      end
      if (r.reg_index == 5'd0) begin
         r.reg_write = 1'b0; r.reg_value = '0;
      end
      if (r.reg_write) gpr[r.reg_index] = r.reg_value;
      pc_q = npc_q;
      npc_q = nf;
      r.fetch_address = pc_q;
      expected_results.push_back(r);
   endtask

   function automatic logic [31:0] rand_reg_op(input logic [5:0] fn);
      return {mieu_pkg::OP_SPECIAL, 5'($urandom), 5'($urandom), 5'($urandom),
              5'($urandom), fn};
   endfunction

   // mostly supported instructions, some branches, some noise
   function automatic logic [31:0] rand_instr();
      logic [5:0] fns [32];
      logic [5:0] ops [14];
      logic [4:0] ris [4];
      int         sel;
      fns = '{mieu_pkg::FN_SLL, mieu_pkg::FN_SRL, mieu_pkg::FN_SRA, mieu_pkg::FN_SLLV,
              mieu_pkg::FN_SRLV, mieu_pkg::FN_SRAV, mieu_pkg::FN_JR, mieu_pkg::FN_JALR,
              mieu_pkg::FN_SYNC, mieu_pkg::FN_MFHI, mieu_pkg::FN_MTHI, mieu_pkg::FN_MFLO,
              mieu_pkg::FN_MTLO, mieu_pkg::FN_DSLLV, mieu_pkg::FN_DSRLV,
              mieu_pkg::FN_DSRAV, mieu_pkg::FN_ADDU, mieu_pkg::FN_SUBU, mieu_pkg::FN_AND,
              mieu_pkg::FN_OR, mieu_pkg::FN_XOR, mieu_pkg::FN_NOR, mieu_pkg::FN_SLT,
              mieu_pkg::FN_SLTU, mieu_pkg::FN_DADDU, mieu_pkg::FN_DSUBU,
              mieu_pkg::FN_DSLL, mieu_pkg::FN_DSRL, mieu_pkg::FN_DSRA,
              mieu_pkg::FN_DSLL32, mieu_pkg::FN_DSRL32, mieu_pkg::FN_DSRA32};
      ops = '{mieu_pkg::OP_J, mieu_pkg::OP_JAL, mieu_pkg::OP_BEQ, mieu_pkg::OP_BNE,
              mieu_pkg::OP_BLEZ, mieu_pkg::OP_BGTZ, mieu_pkg::OP_ADDIU, mieu_pkg::OP_SLTI,
              mieu_pkg::OP_SLTIU, mieu_pkg::OP_ANDI, mieu_pkg::OP_ORI, mieu_pkg::OP_XORI,
              mieu_pkg::OP_LUI, mieu_pkg::OP_DADDIU};
      ris = '{mieu_pkg::RI_BLTZ, mieu_pkg::RI_BGEZ, mieu_pkg::RI_BLTZAL,
              mieu_pkg::RI_BGEZAL};
      sel = $urandom_range(0, 99);
      if (sel < 50) return rand_reg_op(fns[$urandom_range(0, 31)]);
      if (sel < 85) return {ops[$urandom_range(0, 13)], 26'($urandom)};
      if (sel < 93)
         return {mieu_pkg::OP_REGIMM, 5'($urandom), ris[$urandom_range(0, 3)],
                 16'($urandom)};
      return $urandom;
   endfunction

   task automatic wait_drained();
      while (instr_queue.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_start(input logic [31:0] addr);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= addr;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      reload_pc(addr);
   endtask

   int burst_left = 0;
   int gap_left = 0;
   bit accepted_last = 1'b0;
   int stall_mode = 0;
   int cycle_count = 0;

   // driver: bursts with random gaps, fed from instr_queue
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_last) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (instr_queue.size() != 0 && !pausing) begin
               req_valid <= 1'b1;
               req_instr_word <= instr_queue[0];
               if (burst_left == 0) burst_left = $urandom_range(1, 40);
               burst_left--;
               // close the burst with a random gap
               if (burst_left == 0) gap_left = $urandom_range(0, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // accept at the rising edge; the model runs in the same order as the block
   always @(posedge clock) begin
      accepted_last <= !reset && req_valid && req_ready;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (cycle_count % 97 == 0) stall_mode <= $urandom_range(0, 2);
         if (req_valid && req_ready) begin
            execute_instr(instr_queue.pop_front());
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      exec_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
         end else begin
            want = expected_results.pop_front();
            if (want.fetch_address !== rsp_fetch_address || want.reg_write !== rsp_reg_write
                || want.reg_index !== rsp_reg_index || want.reg_value !== rsp_reg_value
                || want.branch_taken !== rsp_branch_taken
                || want.unsupported !== rsp_unsupported) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp pc=%h wr=%b idx=%0d val=%h br=%b un=%b",
                           want.fetch_address, want.reg_write, want.reg_index,
                           want.reg_value, want.branch_taken, want.unsupported);
                  $display("          got pc=%h wr=%b idx=%0d val=%h br=%b un=%b",
                           rsp_fetch_address, rsp_reg_write, rsp_reg_index,
                           rsp_reg_value, rsp_branch_taken, rsp_unsupported);
               end
            end
         end
      end
   end

   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [31:0] starts [4];
      starts = '{32'h0000_0000, 32'hFFFF_FFFC, 32'h7FFF_FFF0, 32'h8000_0000};
      foreach (gpr[i]) gpr[i] = '0;
      hi_q = '0; lo_q = '0;
      reload_pc(mieu_pkg::START_ADDRESS_RESET);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: load extremes, SRA/SRAV/DSRA32/DSLL32 shifts, hi/lo, links, branches
      instr_queue.push_back({mieu_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000});
      instr_queue.push_back({mieu_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd1, 5'd1, 5'd2, 5'd0,
                             mieu_pkg::FN_DADDU});
      instr_queue.push_back({mieu_pkg::OP_DADDIU, 5'd0, 5'd3, 16'hFFFF});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd0, 5'd2, 5'd4, 5'd31,
                             mieu_pkg::FN_SRA});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd3, 5'd2, 5'd5, 5'd0,
                             mieu_pkg::FN_SRAV});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd0, 5'd3, 5'd6, 5'd31,
                             mieu_pkg::FN_DSRA32});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd0, 5'd3, 5'd7, 5'd31,
                             mieu_pkg::FN_DSLL32});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd2, 5'd0, 5'd0, 5'd0,
                             mieu_pkg::FN_MTHI});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd8, 5'd0,
                             mieu_pkg::FN_MFHI});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd3, 5'd3, 5'd0, 5'd0,
                             mieu_pkg::FN_ADDU});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd2, 5'd3, 5'd9, 5'd0,
                             mieu_pkg::FN_SLT});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd2, 5'd3, 5'd10, 5'd0,
                             mieu_pkg::FN_SLTU});
      instr_queue.push_back({mieu_pkg::OP_REGIMM, 5'd31, mieu_pkg::RI_BLTZAL, 16'h0004});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd0,
                             mieu_pkg::FN_SYNC});
      instr_queue.push_back({mieu_pkg::OP_REGIMM, 5'd31, mieu_pkg::RI_BGEZAL, 16'hFFFC});
      instr_queue.push_back({OP_LW, 26'd0});
      instr_queue.push_back({mieu_pkg::OP_JAL, 26'h3FF_FFFF});
      instr_queue.push_back({mieu_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd3, 5'd0, 5'd31, 5'd0,
                             mieu_pkg::FN_JALR});
      instr_queue.push_back({mieu_pkg::OP_BGTZ, 5'd1, 5'd0, 16'h7FFF});
      instr_queue.push_back({mieu_pkg::OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd0, FN_UNLISTED});
      instr_queue.push_back(32'hFFFF_FFFF);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         write_start(starts[ph]);
         for (int i = 0; i < 400; i++) begin
            instr_queue.push_back(rand_instr());
            // hold off once per phase until everything is back
            if (i == 200) begin
               while (instr_queue.size() != 0) @(posedge clock);
               pausing = 1'b1;
               while (expected_results.size() != 0) @(posedge clock);
               pausing = 1'b0;
            end
         end
         wait_drained();
      end
      write_start(mieu_pkg::START_ADDRESS_RESET);
      for (int i = 0; i < 100; i++) instr_queue.push_back(rand_instr());
      wait_drained();

      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== mips64_integer_execute_unit.f =====
hw/rtl/mieu_pkg.sv
hw/rtl/mips64_integer_execute_unit.sv
tb/tb_mips64_integer_execute_unit.sv
